/* src/scl_pkg.sv */
// ----------------------------------------------------------------------------
// scl_pkg: shared types and constants of the soft clipper
// Sample format, blend constants and the request/response structs of the
// digit-serial constant multiplier.
// ----------------------------------------------------------------------------
package scl_pkg;

  // Q2.21 sample
  localparam int unsigned SampleW = 24;

  // Multiplier digit slicing of the (doubled) Q1.23 coefficients
  localparam int unsigned CoefW     = 24;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned MulDigits = CoefW / DigitW;

  // Coefficients in Q1.23, stored doubled so that the 24-bit digit shift
  // lands the product directly on Q2.21
  localparam logic [CoefW-1:0] CoefB2 = 24'd4377424;   // 2 * 0.2609148
  localparam logic [CoefW-1:0] CoefD2 = 24'd12399790;  // 2 * 0.7390851

  // Offsets and clip threshold in Q2.21
  localparam logic signed [SampleW-1:0] OffA    =  24'sd1480214;
  localparam logic signed [SampleW-1:0] OffNegA = -24'sd1480214;
  localparam logic signed [SampleW-1:0] OffC    =  24'sd522551;
  localparam logic signed [SampleW-1:0] OffNegC = -24'sd522551;
  localparam logic signed [SampleW-1:0] ClipThr    =  24'sd2002764;
  localparam logic signed [SampleW-1:0] ClipThrNeg = -24'sd2002764;

  typedef enum logic {
    COEF_B = 1'b0,
    COEF_D = 1'b1
  } coef_sel_e;

  typedef struct packed {
    logic               start;
    logic [SampleW-1:0] x;      // signed Q2.21 operand
    coef_sel_e          coef;
    logic [SampleW-1:0] off;    // signed Q2.21 offset
  } scl_mul_req_t;

  typedef struct packed {
    logic               done;
    logic [SampleW-1:0] res;    // signed Q2.21, saturated
  } scl_mul_rsp_t;

endpackage

/* src/scl_mul.sv */
// ----------------------------------------------------------------------------
// scl_mul: digit-serial constant multiply-add
// Computes sat24(off + round(x * c)) with the coefficient shifted in four
// bits per cycle, LSB first; the partial sum shifts right as digits retire.
// ----------------------------------------------------------------------------
module scl_mul (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  scl_pkg::scl_mul_req_t req_i,
  output scl_pkg::scl_mul_rsp_t rsp_o
);
  import scl_pkg::*;

  localparam int unsigned AccW  = SampleW + DigitW + 2;
  localparam int unsigned ProdW = SampleW + DigitW + 1;
  localparam int unsigned SumW  = SampleW + 2;
  localparam int unsigned CntW  = $clog2(MulDigits);

  localparam logic signed [SumW-1:0] SatMax = SumW'(8388607);
  localparam logic signed [SumW-1:0] SatMin = -SumW'(8388608);

  logic                    busy_q, busy_d;
  logic                    fin_q, fin_d;
  logic                    done_q, done_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic signed [AccW-1:0]  acc_q, acc_d;
  logic [SampleW-1:0]      x_q, x_d;
  logic [CoefW-1:0]        coef_q, coef_d;
  logic [SampleW-1:0]      off_q, off_d;
  logic [SampleW-1:0]      res_q, res_d;

  logic signed [ProdW-1:0] prod;
  logic signed [AccW-1:0]  step_sum;
  logic signed [SumW-1:0]  fin_sum;

  assign prod     = ProdW'($signed(x_q)) *
                    ProdW'($signed({1'b0, coef_q[DigitW-1:0]}));
  assign step_sum = acc_q + AccW'(prod);
  assign fin_sum  = SumW'(acc_q) + SumW'($signed(off_q));

  always_comb begin
    busy_d = busy_q;
    fin_d  = 1'b0;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    x_d    = x_q;
    coef_d = coef_q;
    off_d  = off_q;
    res_d  = res_q;

    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      // rounding half: 2^23 at the doubled scale
      acc_d  = AccW'(1) <<< (CoefW - 1);
      x_d    = req_i.x;
      coef_d = (req_i.coef == COEF_D) ? CoefD2 : CoefB2;
      off_d  = req_i.off;
    end else if (busy_q) begin
      // retire one digit: add, then drop its four low bits
      acc_d  = step_sum >>> DigitW;
      coef_d = coef_q >> DigitW;
      cnt_d  = cnt_q + CntW'(1);
      if (cnt_q == CntW'(MulDigits - 1)) begin
        busy_d = 1'b0;
        fin_d  = 1'b1;
      end
    end

    if (fin_q) begin
      done_d = 1'b1;
      if (fin_sum > SatMax) begin
        res_d = SampleW'(SatMax);
      end else if (fin_sum < SatMin) begin
        res_d = SampleW'(SatMin);
      end else begin
        res_d = SampleW'(fin_sum);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      fin_q  <= fin_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    x_q    <= x_d;
    coef_q <= coef_d;
    off_q  <= off_d;
    res_q  <= res_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

endmodule

/* src/soft_clipper_with_lookahead.sv */
// ----------------------------------------------------------------------------
// soft_clipper_with_lookahead: clip-only soft clipper, one sample lookahead
// Saturating Q2.21 clipper that rounds the edges into and out of a clip.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one signed Q2.21 sample per beat. m_axis returns one beat
//   per input beat: the previously held (possibly softened) sample in tdata
//   and, in tuser, whether a clip is pending after this sample.
//   The output is one sample behind the input; after reset the held sample
//   is zero, so the first output beat carries zero.
//   Each beat walks four checks in order (pending positive clip, positive
//   clip, pending negative clip, negative clip); a check that fires runs one
//   blend through a shared 4-bit-per-cycle multiply-add.
//   An item needs 0 to 2 blends for real inputs, and the next item is
//   accepted only after the current one is written to the output register.
//   The result sits in an output register, so the next beat is accepted
//   while it waits; if the receiver stalls, the block finishes the next item
//   and then holds it until the output register drains.
//   Reset (rst_ni low, asynchronous) clears the held sample, the clip flags
//   and the output valid; the block returns to idle, ready for input.
// ----------------------------------------------------------------------------
module soft_clipper_with_lookahead (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  logic [scl_pkg::SampleW-1:0] s_axis_tdata_i,   // [23:0] sample_in
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  output logic [scl_pkg::SampleW-1:0] m_axis_tdata_o,   // [23:0] sample_out
  output logic                       m_axis_tuser_o     // [0] clipped
);
  import scl_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EVAL = 4'b0010,
    S_MUL  = 4'b0100,
    S_WB   = 4'b1000
  } state_e;

  typedef enum logic [1:0] {
    PH_POS_PEND = 2'd0,
    PH_POS_CLIP = 2'd1,
    PH_NEG_PEND = 2'd2,
    PH_NEG_CLIP = 2'd3
  } phase_e;

  state_e             state_q, state_d;
  phase_e             phase_q, phase_d, phase_nxt;
  logic               dest_held_q, dest_held_d;
  logic               pos_q, pos_d;
  logic               neg_q, neg_d;
  logic [SampleW-1:0] held_q, held_d;
  logic [SampleW-1:0] smp_q, smp_d;
  logic               mvalid_q, mvalid_d;
  logic [SampleW-1:0] mdata_q, mdata_d;
  logic               muser_q, muser_d;

  scl_mul_req_t       mul_req;
  scl_mul_rsp_t       mul_rsp;

  logic signed [SampleW-1:0] smp_s, held_s;
  logic                      out_free;

  assign smp_s    = $signed(smp_q);
  assign held_s   = $signed(held_q);
  assign out_free = !mvalid_q || m_axis_tready_i;

  always_comb begin
    case (phase_q)
      PH_POS_PEND: phase_nxt = PH_POS_CLIP;
      PH_POS_CLIP: phase_nxt = PH_NEG_PEND;
      PH_NEG_PEND: phase_nxt = PH_NEG_CLIP;
      default:     phase_nxt = PH_POS_PEND;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    dest_held_d = dest_held_q;
    pos_d       = pos_q;
    neg_d       = neg_q;
    held_d      = held_q;
    smp_d       = smp_q;
    mdata_d     = mdata_q;
    muser_d     = muser_q;
    mvalid_d    = mvalid_q && !m_axis_tready_i;

    mul_req       = '0;
    mul_req.x     = held_q;
    mul_req.coef  = COEF_B;
    mul_req.off   = OffA;

    s_axis_tready_o = (state_q == S_IDLE);

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          smp_d   = s_axis_tdata_i;
          phase_d = PH_POS_PEND;
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        case (phase_q)
          PH_POS_PEND: begin
            pos_d = 1'b0;
            if (pos_q) begin
              mul_req.start = 1'b1;
              dest_held_d   = 1'b1;
              if (smp_s < held_s) begin
                mul_req.x = smp_q;
              end else begin
                mul_req.coef = COEF_D;
                mul_req.off  = OffC;
              end
            end
          end
          PH_POS_CLIP: begin
            if (smp_s > ClipThr) begin
              pos_d         = 1'b1;
              mul_req.start = 1'b1;
              dest_held_d   = 1'b0;
            end
          end
          PH_NEG_PEND: begin
            neg_d = 1'b0;
            if (neg_q) begin
              mul_req.start = 1'b1;
              dest_held_d   = 1'b1;
              if (smp_s > held_s) begin
                mul_req.x   = smp_q;
                mul_req.off = OffNegA;
              end else begin
                mul_req.coef = COEF_D;
                mul_req.off  = OffNegC;
              end
            end
          end
          default: begin
            if (smp_s < ClipThrNeg) begin
              neg_d         = 1'b1;
              mul_req.start = 1'b1;
              dest_held_d   = 1'b0;
              mul_req.off   = OffNegA;
            end
          end
        endcase
        if (mul_req.start) begin
          state_d = S_MUL;
        end else begin
          phase_d = phase_nxt;
          state_d = (phase_q == PH_NEG_CLIP) ? S_WB : S_EVAL;
        end
      end
      S_MUL: begin
        if (mul_rsp.done) begin
          if (dest_held_q) begin
            held_d = mul_rsp.res;
          end else begin
            smp_d = mul_rsp.res;
          end
          phase_d = phase_nxt;
          state_d = (phase_q == PH_NEG_CLIP) ? S_WB : S_EVAL;
        end
      end
      S_WB: begin
        // hold until the output register drains
        if (out_free) begin
          mdata_d  = held_q;
          muser_d  = pos_q || neg_q;
          mvalid_d = 1'b1;
          held_d   = smp_q;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  scl_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      phase_q  <= PH_POS_PEND;
      pos_q    <= 1'b0;
      neg_q    <= 1'b0;
      held_q   <= '0;
      mvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      neg_q    <= neg_d;
      held_q   <= held_d;
      mvalid_q <= mvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dest_held_q <= dest_held_d;
    smp_q       <= smp_d;
    mdata_q     <= mdata_d;
    muser_q     <= muser_d;
  end

  assign m_axis_tvalid_o = mvalid_q;
  assign m_axis_tdata_o  = mdata_q;
  assign m_axis_tuser_o  = muser_q;

`ifndef NO_ASSERTIONS
  // the two clip flags are never both pending between items
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !(pos_q && neg_q))
    else $error("both clip flags pending between items");

  // the multiplier only answers while the sequencer waits for it
  a_mul_done_in_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_rsp.done |-> (state_q == S_MUL))
    else $error("multiplier result outside of a multiply step");

  // a write-back into a free output register shows a beat next cycle
  a_wb_presents: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_WB) && out_free) |=> (m_axis_tvalid_o && (state_q == S_IDLE)))
    else $error("write-back did not present an output beat");

  // no new multiply is launched while waiting on one
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL) |-> !mul_req.start)
    else $error("multiply started while another is running");
`endif

endmodule
